[rtl/core/its_pkg.sv]
`default_nettype none

package its_pkg;

    // buffer depth, a power of two from 2 to 4 (the index fields are two bits wide)
    localparam int BUF_DEPTH = 4;
    localparam int PTR_W     = $clog2(BUF_DEPTH);

    localparam logic [7:0] DEV_ADDR_RST = 8'hA0;
    localparam logic [2:0] XFER_CNT_RST = 3'd5;

    typedef enum logic [1:0] {
        REQ_EVENT    = 2'd0,
        REQ_START_WR = 2'd1,
        REQ_START_RD = 2'd2,
        REQ_LOAD     = 2'd3
    } t_req;

    typedef enum logic {
        CFG_DEVICE_ADDRESS = 1'b0,
        CFG_TRANSFER_COUNT = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        t_req       req_type;
        logic       bus_busy;
        logic       stop_seen;
        logic       arb_lost;
        logic       is_master;
        logic       transmit_mode;
        logic       ack_received;
        logic       addr_matched;
        logic [7:0] data_byte;
        logic [7:0] sub_address;
        logic [1:0] buf_index;
    } t_item;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       start_gen;
        logic       stop_gen;
        logic       ack_disable;
        logic       engine_reinit;
        logic       store_valid;
        logic [1:0] store_index;
        logic [7:0] store_byte;
        logic       key_valid;
        logic [7:0] key_code;
    } t_result;

endpackage

`default_nettype wire

[rtl/core/i2c_transaction_sequencer.sv]
// a result is registered on the master side when its transfer is taken, via the skid entry while stalled
// throughput: one item per cycle; the only limit is the two-entry output stage
// (output register plus skid), so ready drops only while both entries are full
// reset: synchronous, active low; clears the sequence state, the output stage and
// loads the device address and byte count defaults; buffer entries are not cleared
`default_nettype none

module i2c_transaction_sequencer
    import its_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write port
    input  wire logic        i_cfg_wr_en,
    input  wire logic        i_cfg_index,
    input  wire logic [7:0]  i_cfg_wdata,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // bus_busy, stop_seen, arb_lost, is_master, transmit_mode, ack_received,
    // addr_matched, data_byte[7:0], sub_address[7:0], buf_index[1:0], zero fill
    input  wire logic [31:0] s_axis_tdata,
    // req_type[1:0]
    input  wire logic [1:0]  s_axis_tuser,
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tx_valid, tx_byte[7:0], start_gen, stop_gen, ack_disable, engine_reinit,
    // store_valid, store_index[1:0], store_byte[7:0], key_valid, key_code[7:0],
    // zero fill
    output logic [39:0]      m_axis_tdata
);

    logic [7:0] r_dev_addr;
    logic [2:0] r_xfer_cnt;
    t_item      item;
    t_result    result;
    logic       accept;

    t_result    r_out;
    logic       r_out_vld;
    t_result    r_skid;
    logic       r_skid_vld;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr <= DEV_ADDR_RST;
            r_xfer_cnt <= XFER_CNT_RST;
        end else if (i_cfg_wr_en) begin
            if (i_cfg_index == CFG_DEVICE_ADDRESS) begin
                r_dev_addr <= i_cfg_wdata;
            end else begin
                r_xfer_cnt <= i_cfg_wdata[2:0];
            end
        end
    end

    // unpack the incoming transfer
    always_comb begin
        item.req_type      = t_req'(s_axis_tuser);
        item.bus_busy      = s_axis_tdata[0];
        item.stop_seen     = s_axis_tdata[1];
        item.arb_lost      = s_axis_tdata[2];
        item.is_master     = s_axis_tdata[3];
        item.transmit_mode = s_axis_tdata[4];
        item.ack_received  = s_axis_tdata[5];
        item.addr_matched  = s_axis_tdata[6];
        item.data_byte     = s_axis_tdata[14:7];
        item.sub_address   = s_axis_tdata[22:15];
        item.buf_index     = s_axis_tdata[24:23];
    end

    // skid stage decouples input ready from output ready
    assign s_axis_tready = !r_skid_vld;
    assign accept        = s_axis_tvalid && s_axis_tready;

    its_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_item           (item),
        .i_device_address (r_dev_addr),
        .i_transfer_count (r_xfer_cnt),
        .o_result         (result)
    );

    // output register and skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (m_axis_tready || !r_out_vld) begin
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld  <= accept;
            end
        end else if (accept) begin
            r_skid_vld <= 1'b1;
        end
    end

    // payload side, no reset needed
    always_ff @(posedge i_clk) begin
        if (m_axis_tready || !r_out_vld) begin
            if (r_skid_vld) begin
                r_out <= r_skid;
            end else if (accept) begin
                r_out <= result;
            end
        end else if (accept) begin
            r_skid <= result;
        end
    end

    assign m_axis_tvalid = r_out_vld;

    // pack the result, first field in the lowest bit
    assign m_axis_tdata = {
        7'd0,
        r_out.key_code,
        r_out.key_valid,
        r_out.store_byte,
        r_out.store_index,
        r_out.store_valid,
        r_out.engine_reinit,
        r_out.ack_disable,
        r_out.stop_gen,
        r_out.start_gen,
        r_out.tx_byte,
        r_out.tx_valid
    };

endmodule

`default_nettype wire

[rtl/core/its_ctrl.sv]
`default_nettype none

module its_ctrl
    import its_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire t_item      i_item,
    input  wire logic [7:0] i_device_address,
    input  wire logic [2:0] i_transfer_count,
    output t_result         o_result
);

    logic [7:0]       r_buf [BUF_DEPTH];
    logic [PTR_W-1:0] r_ptr;
    logic [2:0]       r_cnt;
    logic [7:0]       r_sub_hold;
    logic             r_sub_pend;
    logic             r_rd_pend;
    logic             r_first;

    logic [PTR_W-1:0] n_ptr;
    logic [2:0]       n_cnt;
    logic [7:0]       n_sub_hold;
    logic             n_sub_pend;
    logic             n_rd_pend;
    logic             n_first;

    logic             wr_en;
    logic [PTR_W-1:0] wr_idx;
    logic [7:0]       wr_data;
    logic [PTR_W-1:0] rd_idx;
    logic [7:0]       rd_data;
    logic [2:0]       cnt_dec;
    t_result          res;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] q;
        if (p == PTR_W'(BUF_DEPTH - 1)) begin
            q = '0;
        end else begin
            q = p + PTR_W'(1);
        end
        return q;
    endfunction

    // single read port: the slave transmit match takes its offset from entry zero
    assign rd_idx  = (!i_item.is_master && i_item.addr_matched) ? PTR_W'(r_buf[0]) : r_ptr;
    assign rd_data = r_buf[rd_idx];
    assign cnt_dec = r_cnt - 3'd1;

    always_comb begin
        res        = '0;
        n_ptr      = r_ptr;
        n_cnt      = r_cnt;
        n_sub_hold = r_sub_hold;
        n_sub_pend = r_sub_pend;
        n_rd_pend  = r_rd_pend;
        n_first    = r_first;
        wr_en      = 1'b0;
        wr_idx     = r_ptr;
        wr_data    = i_item.data_byte;

        case (i_item.req_type)
            REQ_START_WR, REQ_START_RD: begin
                res.engine_reinit = i_item.bus_busy;
                n_cnt             = i_transfer_count;
                n_sub_hold        = i_item.sub_address;
                n_sub_pend        = 1'b1;
                n_rd_pend         = (i_item.req_type == REQ_START_RD);
                n_ptr             = '0;
                res.tx_valid      = 1'b1;
                res.tx_byte       = i_device_address;
                res.start_gen     = 1'b1;
            end
            REQ_LOAD: begin
                wr_en  = 1'b1;
                wr_idx = PTR_W'(i_item.buf_index);
            end
            default: begin
                if (i_item.stop_seen || i_item.arb_lost) begin
                    res.engine_reinit = 1'b1;
                end else if (i_item.is_master) begin
                    if (i_item.transmit_mode) begin
                        if (!i_item.ack_received) begin
                            res.stop_gen = 1'b1;
                        end else if (r_sub_pend) begin
                            n_sub_pend   = 1'b0;
                            res.tx_valid = 1'b1;
                            res.tx_byte  = r_sub_hold;
                        end else if (r_rd_pend) begin
                            // repeated start with the read address
                            n_rd_pend     = 1'b0;
                            res.tx_valid  = 1'b1;
                            res.tx_byte   = i_device_address + 8'd1;
                            res.start_gen = 1'b1;
                            n_ptr         = '0;
                        end else begin
                            n_cnt = cnt_dec;
                            if (cnt_dec != 3'd0) begin
                                res.tx_valid = 1'b1;
                                res.tx_byte  = rd_data;
                                n_ptr        = ptr_inc(r_ptr);
                            end else begin
                                res.stop_gen = 1'b1;
                            end
                        end
                    end else begin
                        n_cnt = cnt_dec;
                        if (cnt_dec != 3'd0) begin
                            res.ack_disable = (cnt_dec == 3'd1);
                            wr_en           = 1'b1;
                            res.store_valid = 1'b1;
                            res.store_index = 2'(r_ptr);
                            res.store_byte  = i_item.data_byte;
                            n_ptr           = ptr_inc(r_ptr);
                        end else begin
                            res.stop_gen = 1'b1;
                        end
                    end
                end else if (i_item.addr_matched) begin
                    if (i_item.transmit_mode) begin
                        res.tx_valid = 1'b1;
                        res.tx_byte  = rd_data;
                        n_ptr        = ptr_inc(rd_idx);
                    end else begin
                        n_ptr   = '0;
                        n_first = 1'b1;
                    end
                end else if (i_item.transmit_mode) begin
                    if (i_item.ack_received) begin
                        res.tx_valid = 1'b1;
                        res.tx_byte  = rd_data;
                        n_ptr        = ptr_inc(r_ptr);
                    end else begin
                        res.stop_gen = 1'b1;
                    end
                end else begin
                    wr_en           = 1'b1;
                    res.store_valid = 1'b1;
                    res.store_index = 2'(r_ptr);
                    res.store_byte  = i_item.data_byte;
                    n_ptr           = ptr_inc(r_ptr);
                    if (r_first) begin
                        // key code is entry zero after this store
                        n_first       = 1'b0;
                        res.key_valid = 1'b1;
                        res.key_code  = (r_ptr == '0) ? i_item.data_byte : r_buf[0];
                    end
                end
            end
        endcase
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (i_accept && wr_en) begin
            r_buf[wr_idx] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr      <= '0;
            r_cnt      <= '0;
            r_sub_hold <= '0;
            r_sub_pend <= 1'b0;
            r_rd_pend  <= 1'b0;
            r_first    <= 1'b0;
        end else if (i_accept) begin
            r_ptr      <= n_ptr;
            r_cnt      <= n_cnt;
            r_sub_hold <= n_sub_hold;
            r_sub_pend <= n_sub_pend;
            r_rd_pend  <= n_rd_pend;
            r_first    <= n_first;
        end
    end

endmodule

`default_nettype wire
